// ----- rtl/core/bta_pkg.sv -----
// Shared constants and helper functions for the boundary-tag heap allocator.
// No dependencies.
`default_nettype none
package bta_pkg;

  localparam int OPC_W = 2;
  localparam int SZ_W  = 21;
  localparam int OFF_W = 20;

  localparam logic [OPC_W-1:0] OP_ALLOC_FIRST = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC_BEST  = 2'd1;
  localparam logic [OPC_W-1:0] OP_FREE        = 2'd2;
  localparam logic [OPC_W-1:0] OP_RESIZE      = 2'd3;

  localparam logic [31:0] OVH_GRAN   = 32'd3;
  localparam logic [31:0] HDR_BYTES  = 32'd16;
  localparam logic [31:0] SPLIT_MIN  = 32'd32;

  function automatic logic [31:0] usable(logic [31:0] n);
    return (n >= OVH_GRAN) ? ((n - OVH_GRAN) << 3) : 32'd0;
  endfunction

  function automatic logic [OFF_W-1:0] region_of(logic [31:0] g);
    logic [31:0] t;
    t = (g << 3) + HDR_BYTES;
    return t[OFF_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bta_if.sv -----
// Request and response channel interfaces for the heap allocator.
// Depends on bta_pkg.
`default_nettype none
interface bta_req_if;
  logic                      valid;
  logic                      ready;
  logic [bta_pkg::OPC_W-1:0] opcode;
  logic [bta_pkg::SZ_W-1:0]  request_size;
  logic [bta_pkg::OFF_W-1:0] region_offset;
  logic                      has_region;
  modport source (output valid, opcode, request_size, region_offset, has_region,
                  input ready);
  modport sink (input valid, opcode, request_size, region_offset, has_region,
                output ready);
endinterface

interface bta_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bta_pkg::OFF_W-1:0] result_offset;
  logic                      success;
  logic                      moved;
  modport source (output valid, result_offset, success, moved, input ready);
  modport sink (input valid, result_offset, success, moved, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bta_ram.sv -----
// Single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none
module bta_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/boundary_tag_heap_allocator.sv -----
// Boundary-tag heap allocator: one request at a time under a sequencer.
// An allocate scan walks the blocks in address order; a held response stalls
// completion. ready is high only when idle, so no new request is taken
// until the last one has left the sequencer.
// After reset a clearing pass over every granule runs before the
// first request is taken; the arena then holds one free block.
`default_nettype none
module boundary_tag_heap_allocator #(
  parameter int ARENA_GRANULES = 131072
) (
  input wire logic clk,
  input wire logic rst_n,
  bta_req_if.sink   in_req,
  bta_rsp_if.source out_rsp
);
  localparam int AW = $clog2(ARENA_GRANULES);
  localparam int GW = $clog2(ARENA_GRANULES + 1);
  localparam int EW = GW + 2;
  localparam logic [31:0] AR = 32'(ARENA_GRANULES);

  typedef enum logic [20:0] {
    ST_CLR    = 21'h000001, ST_INIT   = 21'h000002, ST_IDLE   = 21'h000004,
    ST_CHK    = 21'h000008, ST_RS_NEV = 21'h000010, ST_RS_N2  = 21'h000020,
    ST_RS_N3  = 21'h000040, ST_RS_PEV = 21'h000080, ST_RS_P2  = 21'h000100,
    ST_RS_P3  = 21'h000200, ST_SCAN   = 21'h000400, ST_ALC    = 21'h000800,
    ST_ALC2   = 21'h001000, ST_FR0    = 21'h002000, ST_FR_PRV = 21'h004000,
    ST_FR_PEV = 21'h008000, ST_FR_PMG = 21'h010000, ST_FR_NX  = 21'h020000,
    ST_FR_NEV = 21'h040000, ST_FR_NMG = 21'h080000, ST_DONE   = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [bta_pkg::OPC_W-1:0] op_r, op_nxt;
  logic [bta_pkg::SZ_W-1:0]  sz_r, sz_nxt;
  logic best_r, best_nxt, rsz_r, rsz_nxt, pickv_r, pickv_nxt, nxv_r, nxv_nxt;
  logic [AW-1:0] g_r, g_nxt, p_r, p_nxt, fb_r, fb_nxt, pick_r, pick_nxt;
  logic [AW-1:0] cur_r, cur_nxt, nx_r, nx_nxt;
  logic [GW-1:0] n_r, n_nxt, pn_r, pn_nxt, nn_r, nn_nxt, fn_r, fn_nxt;
  logic [GW-1:0] pickn_r, pickn_nxt;
  logic [bta_pkg::SZ_W:0] need_r, need_nxt;
  logic [bta_pkg::OFF_W-1:0] res_r, res_nxt, out_res_r, out_res_nxt;
  logic ok_r, ok_nxt, mv_r, mv_nxt, out_ok_r, out_ok_nxt, out_mv_r, out_mv_nxt;

  logic          bm_we, ft_we;
  logic [AW-1:0] bm_wa, bm_ra, ft_wa, ft_ra, ft_wd, ft_q;
  logic [EW-1:0] bm_wd, bm_q;

  logic        q_st, q_al, fit;
  logic [31:0] q_sz, use_q, gq, g32, n32, p32, pn32, nn32, fb32, fn32, nx32;
  logic [31:0] ng32, pk32, pkn32, asz, a32, cur32, t32, old32;

  bta_ram #(.DEPTH(ARENA_GRANULES), .WIDTH(EW)) u_block_map (
    .clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd), .raddr(bm_ra), .rdata(bm_q)
  );
  bta_ram #(.DEPTH(ARENA_GRANULES), .WIDTH(AW)) u_foot_map (
    .clk(clk), .we(ft_we), .waddr(ft_wa), .wdata(ft_wd), .raddr(ft_ra), .rdata(ft_q)
  );

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.result_offset = out_res_r;
  assign out_rsp.success       = out_ok_r;
  assign out_rsp.moved         = out_mv_r;

  assign q_st  = bm_q[GW+1];
  assign q_al  = bm_q[GW];
  assign q_sz  = 32'(bm_q[GW-1:0]);
  assign use_q = bta_pkg::usable(q_sz);
  assign g32   = 32'(g_r);
  assign n32   = 32'(n_r);
  assign p32   = 32'(p_r);
  assign pn32  = 32'(pn_r);
  assign nn32  = 32'(nn_r);
  assign fb32  = 32'(fb_r);
  assign fn32  = 32'(fn_r);
  assign nx32  = 32'(nx_r);
  assign pk32  = 32'(pick_r);
  assign pkn32 = 32'(pickn_r);
  assign cur32 = 32'(cur_r);
  assign ng32  = 32'(need_r[bta_pkg::SZ_W:3]);
  assign asz   = (32'(sz_r) + 32'd7) & ~32'd7;
  assign a32   = asz >> 3;
  assign gq    = (32'(in_req.region_offset) - bta_pkg::HDR_BYTES) >> 3;
  assign old32 = bta_pkg::usable(q_sz);
  assign fit   = q_st && !q_al && (use_q >= 32'(sz_r));

  always_comb begin
    state_nxt = state_r;     clr_nxt = clr_r;       out_valid_nxt = out_valid_r;
    op_nxt = op_r;           sz_nxt = sz_r;         best_nxt = best_r;
    rsz_nxt = rsz_r;         pickv_nxt = pickv_r;   nxv_nxt = nxv_r;
    g_nxt = g_r;             p_nxt = p_r;           fb_nxt = fb_r;
    pick_nxt = pick_r;       cur_nxt = cur_r;       nx_nxt = nx_r;
    n_nxt = n_r;             pn_nxt = pn_r;         nn_nxt = nn_r;
    fn_nxt = fn_r;           pickn_nxt = pickn_r;   need_nxt = need_r;
    res_nxt = res_r;         ok_nxt = ok_r;         mv_nxt = mv_r;
    out_res_nxt = out_res_r; out_ok_nxt = out_ok_r; out_mv_nxt = out_mv_r;
    bm_we = 1'b0; bm_wa = '0; bm_wd = '0; bm_ra = '0;
    ft_we = 1'b0; ft_wa = '0; ft_wd = '0; ft_ra = '0;
    t32 = 32'd0;

    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        bm_we = 1'b1;
        bm_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == AR - 32'd1) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        bm_we = 1'b1;
        bm_wd = {1'b1, 1'b0, GW'(AR)};
        ft_we = 1'b1;
        ft_wa = AW'(AR - 32'd1);
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          op_nxt = in_req.opcode;
          sz_nxt = in_req.request_size;
          res_nxt = '0;
          ok_nxt = 1'b0;
          mv_nxt = 1'b0;
          rsz_nxt = 1'b0;
          cur_nxt = '0;
          pickv_nxt = 1'b0;
          best_nxt = 1'b1;
          if (in_req.opcode == bta_pkg::OP_ALLOC_FIRST ||
              in_req.opcode == bta_pkg::OP_ALLOC_BEST || !in_req.has_region) begin
            if (in_req.opcode == bta_pkg::OP_FREE) begin
              ok_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              best_nxt = (in_req.opcode != bta_pkg::OP_ALLOC_FIRST);
              state_nxt = ST_SCAN;
            end
          end else if (in_req.region_offset < 20'd16 || in_req.region_offset[2:0] != 3'd0
                       || gq >= AR) begin
            state_nxt = ST_DONE;
          end else begin
            g_nxt = gq[AW-1:0];
            bm_ra = gq[AW-1:0];
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        n_nxt = bm_q[GW-1:0];
        if (!(q_st && q_al)) begin
          state_nxt = ST_DONE;
        end else if (op_r == bta_pkg::OP_FREE) begin
          ok_nxt = 1'b1;
          state_nxt = ST_FR0;
        end else if (old32 >= 32'(sz_r)) begin
          res_nxt = bta_pkg::region_of(g32);
          ok_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          t32 = ((32'(sz_r) - old32) + 32'd7) & ~32'd7;
          need_nxt = t32[bta_pkg::SZ_W:0];
          t32 = g32 + q_sz;
          nxv_nxt = (t32 < AR);
          nx_nxt = t32[AW-1:0];
          bm_ra = t32[AW-1:0];
          ft_ra = g_r - 1'b1;
          state_nxt = ST_RS_NEV;
        end
      end
      ST_RS_NEV: begin
        if (nxv_r && q_st && !q_al && use_q >= 32'(need_r)) begin
          nn_nxt = bm_q[GW-1:0];
          bm_we = 1'b1;
          bm_wa = nx_r;
          state_nxt = ST_RS_N2;
        end else if (g_r != '0) begin
          p_nxt = ft_q;
          bm_ra = ft_q;
          state_nxt = ST_RS_PEV;
        end else begin
          rsz_nxt = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_RS_N2: begin
        bm_we = 1'b1;
        bm_wa = g_r;
        bm_wd = {1'b1, 1'b1, GW'(n32 + ng32)};
        ft_we = 1'b1;
        ft_wa = AW'(g32 + n32 + ng32 - 32'd1);
        ft_wd = g_r;
        state_nxt = ST_RS_N3;
      end
      ST_RS_N3: begin
        bm_we = 1'b1;
        bm_wa = AW'(nx32 + ng32);
        bm_wd = {1'b1, 1'b0, GW'(nn32 - ng32)};
        ft_we = 1'b1;
        ft_wa = AW'(nx32 + nn32 - 32'd1);
        ft_wd = AW'(nx32 + ng32);
        res_nxt = bta_pkg::region_of(g32);
        ok_nxt = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_RS_PEV: begin
        if (p32 < g32 && q_st && !q_al && p32 + q_sz == g32 && use_q >= 32'(need_r)) begin
          pn_nxt = bm_q[GW-1:0];
          bm_we = 1'b1;
          bm_wa = p_r;
          bm_wd = {1'b1, 1'b0, GW'(q_sz - ng32)};
          ft_we = 1'b1;
          ft_wa = AW'(p32 + q_sz - ng32 - 32'd1);
          ft_wd = p_r;
          state_nxt = ST_RS_P2;
        end else begin
          rsz_nxt = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_RS_P2: begin
        bm_we = 1'b1;
        bm_wa = g_r;
        state_nxt = ST_RS_P3;
      end
      ST_RS_P3: begin
        bm_we = 1'b1;
        bm_wa = AW'(g32 - ng32);
        bm_wd = {1'b1, 1'b1, GW'(n32 + ng32)};
        ft_we = 1'b1;
        ft_wa = AW'(g32 + n32 - 32'd1);
        ft_wd = AW'(g32 - ng32);
        res_nxt = bta_pkg::region_of(g32 - ng32);
        ok_nxt = 1'b1;
        mv_nxt = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        t32 = cur32 + q_sz;
        if (q_sz == 32'd0 || !q_st) begin
          state_nxt = ST_ALC;
        end else if (fit && !best_r) begin
          pick_nxt = cur_r;
          pickn_nxt = bm_q[GW-1:0];
          pickv_nxt = 1'b1;
          state_nxt = ST_ALC;
        end else begin
          if (fit && (!pickv_r || bta_pkg::usable(pkn32) > use_q)) begin
            pick_nxt = cur_r;
            pickn_nxt = bm_q[GW-1:0];
            pickv_nxt = 1'b1;
          end
          if (t32 >= AR) begin
            state_nxt = ST_ALC;
          end else begin
            cur_nxt = t32[AW-1:0];
            bm_ra = t32[AW-1:0];
          end
        end
      end
      ST_ALC, ST_ALC2: begin
        if (!pickv_r) begin
          state_nxt = ST_DONE;
        end else begin
          if (state_r == ST_ALC && bta_pkg::usable(pkn32) >= asz + bta_pkg::SPLIT_MIN) begin
            bm_we = 1'b1;
            bm_wa = pick_r;
            bm_wd = {1'b1, 1'b1, GW'(a32 + bta_pkg::OVH_GRAN)};
            ft_we = 1'b1;
            ft_wa = AW'(pk32 + a32 + bta_pkg::OVH_GRAN - 32'd1);
            ft_wd = pick_r;
            state_nxt = ST_ALC2;
          end else begin
            bm_we = 1'b1;
            if (state_r == ST_ALC) begin
              bm_wa = pick_r;
              bm_wd = {1'b1, 1'b1, pickn_r};
            end else begin
              bm_wa = AW'(pk32 + a32 + bta_pkg::OVH_GRAN);
              bm_wd = {1'b1, 1'b0, GW'(pkn32 - a32 - bta_pkg::OVH_GRAN)};
              ft_we = 1'b1;
              ft_wa = AW'(pk32 + pkn32 - 32'd1);
              ft_wd = AW'(pk32 + a32 + bta_pkg::OVH_GRAN);
            end
            res_nxt = bta_pkg::region_of(pk32);
            ok_nxt = 1'b1;
            mv_nxt = rsz_r;
            state_nxt = rsz_r ? ST_FR0 : ST_DONE;
          end
        end
      end
      ST_FR0: begin
        bm_we = 1'b1;
        bm_wa = g_r;
        bm_wd = {1'b1, 1'b0, n_r};
        fb_nxt = g_r;
        fn_nxt = n_r;
        if (g_r != '0) begin
          ft_ra = g_r - 1'b1;
          state_nxt = ST_FR_PRV;
        end else begin
          state_nxt = ST_FR_NX;
        end
      end
      ST_FR_PRV: begin
        p_nxt = ft_q;
        bm_ra = ft_q;
        state_nxt = ST_FR_PEV;
      end
      ST_FR_PEV: begin
        if (p32 < fb32 && q_st && !q_al && p32 + q_sz == fb32) begin
          pn_nxt = bm_q[GW-1:0];
          bm_we = 1'b1;
          bm_wa = fb_r;
          state_nxt = ST_FR_PMG;
        end else begin
          state_nxt = ST_FR_NX;
        end
      end
      ST_FR_PMG: begin
        bm_we = 1'b1;
        bm_wa = p_r;
        bm_wd = {1'b1, 1'b0, GW'(pn32 + fn32)};
        ft_we = 1'b1;
        ft_wa = AW'(p32 + pn32 + fn32 - 32'd1);
        ft_wd = p_r;
        fb_nxt = p_r;
        fn_nxt = GW'(pn32 + fn32);
        state_nxt = ST_FR_NX;
      end
      ST_FR_NX: begin
        t32 = fb32 + fn32;
        if (t32 < AR) begin
          nx_nxt = t32[AW-1:0];
          bm_ra = t32[AW-1:0];
          state_nxt = ST_FR_NEV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FR_NEV: begin
        if (q_st && !q_al) begin
          nn_nxt = bm_q[GW-1:0];
          bm_we = 1'b1;
          bm_wa = nx_r;
          state_nxt = ST_FR_NMG;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FR_NMG: begin
        bm_we = 1'b1;
        bm_wa = fb_r;
        bm_wd = {1'b1, 1'b0, GW'(fn32 + nn32)};
        ft_we = 1'b1;
        ft_wa = AW'(fb32 + fn32 + nn32 - 32'd1);
        ft_wd = fb_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = res_r;
          out_ok_nxt = ok_r;
          out_mv_nxt = mv_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;       sz_r <= sz_nxt;       best_r <= best_nxt;
    rsz_r <= rsz_nxt;     pickv_r <= pickv_nxt; nxv_r <= nxv_nxt;
    g_r <= g_nxt;         p_r <= p_nxt;         fb_r <= fb_nxt;
    pick_r <= pick_nxt;   cur_r <= cur_nxt;     nx_r <= nx_nxt;
    n_r <= n_nxt;         pn_r <= pn_nxt;       nn_r <= nn_nxt;
    fn_r <= fn_nxt;       pickn_r <= pickn_nxt; need_r <= need_nxt;
    res_r <= res_nxt;     ok_r <= ok_nxt;       mv_r <= mv_nxt;
    out_res_r <= out_res_nxt;
    out_ok_r <= out_ok_nxt;
    out_mv_r <= out_mv_nxt;
  end
endmodule
`default_nettype wire
